// ----- design/dstwr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_pkg
// Shared types, constants and codes of the double-sided ranging table.
// ----------------------------------------------------------------------------
package dstwr_pkg;

	localparam int ANCHORS = 8;
	localparam int AW = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;
	localparam int TW = 40;

	localparam logic [15:0] TX_DLY_RST = 16'd16414;
	localparam logic [15:0] RX_DLY_RST = 16'd16414;
	localparam logic [23:0] SCALE_RST = 24'd307387;

	typedef enum logic [1:0] {
		ACT_SUPERFRAME = 2'd0,
		ACT_TAG_TX     = 2'd1,
		ACT_ANCHOR_MSG = 2'd2,
		ACT_READ       = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_ID   = 2'd1,
		ST_NO_ROUND = 2'd2,
		ST_ZERO_DIV = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_TX_DLY = 2'd0,
		REG_RX_DLY = 2'd1,
		REG_SCALE  = 2'd2
	} reg_idx_t;

	// Ranging record of one anchor.
	typedef struct packed {
		logic          valid;
		logic [TW-1:0] anchor_tx;
		logic [TW-1:0] anchor_rx;
		logic [TW-1:0] tag_rx;
	} rec_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE, S_DIFF, S_PREP, S_MUL1, S_MUL2, S_SUB, S_SCL, S_DIV, S_OUT
	} state_t;

	// Start, busy and done flags of the divider.
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage
`default_nettype wire

// ----- design/dstwr_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_if
// Valid/ready channel interfaces for items, results and register writes.
// ----------------------------------------------------------------------------
interface dstwr_in_if import dstwr_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [1:0]    action;
	logic [TW-1:0] timestamp;
	logic [7:0]    anchor_id;
	logic [TW-1:0] anchor_tx_ts;
	logic [TW-1:0] tag_rx_ts;
	modport source (output valid, action, timestamp, anchor_id, anchor_tx_ts, tag_rx_ts,
		input ready);
	modport sink (input valid, action, timestamp, anchor_id, anchor_tx_ts, tag_rx_ts,
		output ready);
endinterface

interface dstwr_out_if ();
	logic        valid;
	logic        ready;
	logic [7:0]  result_anchor;
	logic [15:0] distance_mm;
	logic [1:0]  status;
	modport source (output valid, result_anchor, distance_mm, status, input ready);
	modport sink (input valid, result_anchor, distance_mm, status, output ready);
endinterface

interface dstwr_cfg_if ();
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/dstwr_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dstwr_div
// Restoring divider: one quotient bit per cycle, 16 bits plus saturation.
// ----------------------------------------------------------------------------
module dstwr_div import dstwr_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] dividend,
	input  wire logic [42:0]  den,
	output div_ctl_t          ctl,
	output logic [15:0]       quot
);

	logic [127:0] rem_q;
	logic [74:0]  dv_q;
	logic [4:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [15:0]  quot_q;
	logic [127:0] cmp_w;

	// Divisor shifted to the bit under test.
	always_comb begin
		cmp_w = {53'd0, dv_q} << cnt_q[3:0];
	end

	// One compare and subtract per cycle; the first pass tests saturation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
				rem_q  <= dividend;
				dv_q   <= {16'd0, den, 16'd0};
				quot_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == 5'd16) begin
					if (rem_q >= {53'd0, den, 32'd0}) begin
						quot_q <= 16'hFFFF;
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					cnt_q <= 5'd15;
				end else begin
					if (rem_q >= cmp_w) begin
						rem_q <= rem_q - cmp_w;
						quot_q[cnt_q[3:0]] <= 1'b1;
					end
					if (cnt_q == 5'd0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
			end
		end
	end

	assign ctl  = '{start: start, busy: busy_q, done: done_q};
	assign quot = quot_q;

endmodule
`default_nettype wire

// ----- design/uwb_ds_twr_ranging_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uwb_ds_twr_ranging_table
// Two-bank anchor timestamp table with double-sided two-way ranging.
// ----------------------------------------------------------------------------
// Channel  | Dir | Carries
// item     | in  | action, timestamp, anchor_id, anchor_tx_ts, tag_rx_ts
// result   | out | result_anchor, distance_mm, status
// cfg      | in  | index, data (register write)
// Superframe and tag send words give no result; a read or bad id answers next cycle.
// A ranged anchor message answers after 2 differencing steps, two products of 5
// steps each on the shared 32x32 multiplier, a subtract, 4 scaling steps, the
// divider (a saturation test, then quotient bits if it does not saturate) and an output step.
// Reset restores the registers and clears valid bits, bank select and tag send.
// A result word waits in an output register; a stalled result holds off input.
// ----------------------------------------------------------------------------
module uwb_ds_twr_ranging_table import dstwr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	dstwr_in_if.sink    item,
	dstwr_out_if.source result,
	dstwr_cfg_if.sink   cfg
);

	logic [15:0] tx_dly_q, rx_dly_q;
	logic [23:0] scale_q;
	rec_t        bank0_q [ANCHORS];
	rec_t        bank1_q [ANCHORS];
	logic [ANCHORS-1:0] v0_q, v1_q, dval_q;
	logic [15:0] dist_q [ANCHORS];
	logic        cur_q;
	logic [TW-1:0] tag_q;

	state_t state_q, state_d;
	logic [AW-1:0] id_q;
	logic [7:0]    rid_q;
	rec_t          old_q, new_q;
	logic          oldv_q;
	logic [TW-1:0] tr1_q, tr2_q, tp1_q, tp2_q;
	logic [42:0]   den_q;
	logic [63:0]   ra_q, rb_q, da_q, db_q;
	logic [127:0]  acc_q, pr_q;
	logic [2:0]    step_q;
	logic [6:0]    pw_q;
	logic          ovalid_q;
	logic [15:0]   odist_q;
	status_t       ostat_q;
	logic [15:0]   divq_q;

	logic        acc_in, dv_start;
	logic [16:0] d_w;
	logic [42:0] den_w;
	logic        rzero_w;
	div_ctl_t    dctl;
	logic [15:0] quot;
	logic [31:0] ma, mb;
	logic [63:0] mp;
	logic [6:0]  pw_d;
	logic [127:0] mterm;
	logic [63:0] xa, xb;
	logic        in_bad;

	assign acc_in   = item.valid && item.ready;
	assign in_bad   = {1'b0, item.anchor_id} >= 9'(ANCHORS);
	assign item.ready = (state_q == S_IDLE) && !ovalid_q;
	assign cfg.ready  = 1'b1;
	assign d_w      = {1'b0, tx_dly_q} + {1'b0, rx_dly_q};

	// Round sum and sign test of the round terms, used as the round is prepared.
	assign den_w = {3'd0, tr1_q} + {3'd0, tr2_q} + {3'd0, tp1_q} + {3'd0, tp2_q};
	// Ra*Rb is positive only when both signs agree and neither is zero.
	assign rzero_w = (({1'b0, tr1_q} <= {24'd0, d_w}) != ({1'b0, tr2_q} <= {24'd0, d_w})) ||
		({1'b0, tr1_q} == {24'd0, d_w}) || ({1'b0, tr2_q} == {24'd0, d_w});

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_dly_q <= TX_DLY_RST;
			rx_dly_q <= RX_DLY_RST;
			scale_q  <= SCALE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TX_DLY: tx_dly_q <= cfg.data[15:0];
				REG_RX_DLY: rx_dly_q <= cfg.data[15:0];
				REG_SCALE:  scale_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Shared 32x32 multiplier; operands and weight chosen by the step counter.
	always_comb begin
		xa = ra_q;
		xb = rb_q;
		if (state_q == S_MUL2) begin
			xa = da_q;
			xb = db_q;
		end
		ma = step_q[0] ? xa[63:32] : xa[31:0];
		mb = step_q[1] ? xb[63:32] : xb[31:0];
		pw_d = {1'b0, step_q[0], 5'd0} + {1'b0, step_q[1], 5'd0};
		if (state_q == S_SCL) begin
			ma = acc_q[{step_q[1:0], 5'd0} +: 32];
			mb = {8'd0, scale_q};
			pw_d = {step_q[1:0], 5'd0};
		end
	end

	always_ff @(posedge clk) begin
		mp   <= ma * mb;
		pw_q <= pw_d;
	end

	// Product term placed at its weight (registered, so it belongs to the step of the cycle before).
	assign mterm = {64'd0, mp} << pw_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (acc_in && item.action == ACT_ANCHOR_MSG && !in_bad) state_d = S_DIFF;
			S_DIFF: state_d = S_PREP;
			S_PREP: begin
				if (!oldv_q || den_w == '0 || rzero_w) state_d = S_OUT;
				else state_d = S_MUL1;
			end
			S_MUL1: if (step_q == 3'd4) state_d = S_MUL2;
			S_MUL2: if (step_q == 3'd4) state_d = S_SUB;
			S_SUB:  state_d = (pr_q > acc_q) ? S_SCL : S_OUT;
			S_SCL:  if (step_q == 3'd3) state_d = S_DIV;
			S_DIV:  if (dctl.done) state_d = S_OUT;
			S_OUT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign dv_start = (state_q == S_SCL) && (step_q == 3'd3);

	// Sequencer datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			v0_q     <= '0;
			v1_q     <= '0;
			dval_q   <= '0;
			cur_q    <= 1'b0;
			tag_q    <= '0;
			ovalid_q <= 1'b0;
			step_q   <= '0;
		end else begin
			state_q <= state_d;
			if (result.valid && result.ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (acc_in) begin
						id_q  <= item.anchor_id[AW-1:0];
						rid_q <= item.anchor_id;
						case (action_t'(item.action))
							ACT_SUPERFRAME: begin
								cur_q  <= ~cur_q;
								dval_q <= '0;
								if (cur_q) v0_q <= '0;
								else v1_q <= '0;
							end
							ACT_TAG_TX: tag_q <= item.timestamp;
							ACT_READ: begin
								ovalid_q <= 1'b1;
								odist_q  <= '0;
								ostat_q  <= in_bad ? ST_BAD_ID : ST_OK;
								if (!in_bad && dval_q[item.anchor_id[AW-1:0]])
									odist_q <= dist_q[item.anchor_id[AW-1:0]];
							end
							ACT_ANCHOR_MSG: begin
								new_q <= '{1'b1, item.anchor_tx_ts, item.timestamp,
									item.tag_rx_ts};
								if (in_bad) begin
									ovalid_q <= 1'b1;
									odist_q  <= '0;
									ostat_q  <= ST_BAD_ID;
								end else if (cur_q) begin
									old_q  <= bank0_q[item.anchor_id[AW-1:0]];
									oldv_q <= v0_q[item.anchor_id[AW-1:0]];
									v1_q[item.anchor_id[AW-1:0]] <= 1'b1;
								end else begin
									old_q  <= bank1_q[item.anchor_id[AW-1:0]];
									oldv_q <= v1_q[item.anchor_id[AW-1:0]];
									v0_q[item.anchor_id[AW-1:0]] <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_DIFF: begin
					tr1_q <= new_q.tag_rx - old_q.anchor_tx;
					tr2_q <= new_q.anchor_rx - tag_q;
					tp2_q <= new_q.anchor_tx - new_q.tag_rx;
					tp1_q <= tag_q - old_q.anchor_rx;
				end
				S_PREP: begin
					den_q <= den_w;
					ra_q <= ({1'b0, tr1_q} >= {24'd0, d_w}) ?
						64'({1'b0, tr1_q} - {24'd0, d_w}) : 64'({24'd0, d_w} - {1'b0, tr1_q});
					rb_q <= ({1'b0, tr2_q} >= {24'd0, d_w}) ?
						64'({1'b0, tr2_q} - {24'd0, d_w}) : 64'({24'd0, d_w} - {1'b0, tr2_q});
					da_q <= 64'({1'b0, tp2_q} + {24'd0, d_w});
					db_q <= 64'({1'b0, tp1_q} + {24'd0, d_w});
					acc_q  <= '0;
					step_q <= '0;
				end
				S_MUL1, S_MUL2: begin
					// Four partial products, then one step to collect the last.
					step_q <= step_q + 3'd1;
					if (step_q != 3'd0) acc_q <= acc_q + mterm;
					if (step_q == 3'd4) begin
						step_q <= '0;
						if (state_q == S_MUL1) begin
							pr_q  <= acc_q + mterm;
							acc_q <= '0;
						end
					end
				end
				S_SUB: begin
					acc_q  <= pr_q - acc_q;
					pr_q   <= '0;
					step_q <= '0;
				end
				S_SCL: begin
					// Three 32-bit slices of the numerator times the scale.
					step_q <= step_q + 3'd1;
					if (step_q != 3'd0) pr_q <= pr_q + mterm;
				end
				S_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						odist_q  <= '0;
						ostat_q  <= ST_OK;
						if (!oldv_q) ostat_q <= ST_NO_ROUND;
						else if (den_q == '0) ostat_q <= ST_ZERO_DIV;
						else begin
							dval_q[id_q] <= 1'b1;
							dist_q[id_q] <= divq_q;
							odist_q <= divq_q;
						end
					end
				end
				default: ;
			endcase
			if (acc_in && item.action == ACT_ANCHOR_MSG && !in_bad) begin
				if (cur_q) bank1_q[item.anchor_id[AW-1:0]] <= '{1'b1, item.anchor_tx_ts,
					item.timestamp, item.tag_rx_ts};
				else bank0_q[item.anchor_id[AW-1:0]] <= '{1'b1, item.anchor_tx_ts,
					item.timestamp, item.tag_rx_ts};
			end
		end
	end

	// Quotient capture; zero for rounds that never reach the divider.
	always_ff @(posedge clk) begin
		if (state_q == S_PREP || state_q == S_SUB) divq_q <= '0;
		if (dctl.done) divq_q <= quot;
	end

	dstwr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (pr_q + mterm),
		.den      (den_q),
		.ctl      (dctl),
		.quot     (quot)
	);

	assign result.valid         = ovalid_q;
	assign result.result_anchor = rid_q;
	assign result.distance_mm   = odist_q;
	assign result.status        = ostat_q;

	// No input is taken while the sequencer is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !item.ready) else $error("input taken while busy");
	// A bad id never starts a ranging round.
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && in_bad) |=> state_q == S_IDLE) else $error("bad id ranged");
	// The divider is started only from the scaling step.
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.start |-> state_q == S_SCL) else $error("stray divider start");

endmodule
`default_nettype wire

// ----- verif/uwb_ds_twr_ranging_table_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uwb_ds_twr_ranging_table_checker
// Watches the item, result and register channels of the ranging table. It
// keeps its own copy of the banks, tag send time, distance store and delay
// and scale registers. It works out the result owed for each accepted read
// or anchor message; each accepted result word must match the oldest owed.
// ----------------------------------------------------------------------------
module uwb_ds_twr_ranging_table_checker import dstwr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	dstwr_in_if  item,
	dstwr_out_if result,
	dstwr_cfg_if cfg,
	output int   errors,
	output int   owed
);

	typedef struct {
		logic [7:0]  anchor;
		logic [15:0] dist_mm;
		status_t     status;
	} range_word_t;

	range_word_t owed_q[$];

	rec_t        bank[2][ANCHORS];
	logic        cur_bank;
	logic [39:0] tag_send;
	logic [15:0] dist_store[ANCHORS];
	logic [15:0] tx_dly;
	logic [15:0] rx_dly;
	logic [23:0] scale;

	task automatic report(input string msg);
		$display("ERROR: %s", msg);
		errors++;
	endtask

	// Double-sided ranging over one old and one new record.
	function automatic status_t range_mm(input rec_t o, input rec_t n,
			output logic [15:0] dist_mm);
		logic [39:0] t1, t2, r1, r2;
		logic [16:0] d;
		logic [41:0] den;
		longint ra, rb;
		longint unsigned ra_abs, rb_abs;
		logic [127:0] pr, pd, num, prod, dv;
		t1 = n.tag_rx - o.anchor_tx;
		t2 = n.anchor_rx - tag_send;
		r2 = n.anchor_tx - n.tag_rx;
		r1 = tag_send - o.anchor_rx;
		d = {1'b0, tx_dly} + {1'b0, rx_dly};
		den = {2'b0, t1} + {2'b0, t2} + {2'b0, r1} + {2'b0, r2};
		ra = longint'({24'b0, t1}) - longint'({47'b0, d});
		rb = longint'({24'b0, t2}) - longint'({47'b0, d});
		dist_mm = 16'd0;
		if (den == 0)
			return ST_ZERO_DIV;
		// A non-positive product of the round terms gives no distance.
		if ((ra <= 0 || rb <= 0) && !(ra < 0 && rb < 0))
			return ST_OK;
		ra_abs = (ra < 0) ? longint'(-ra) : ra;
		rb_abs = (rb < 0) ? longint'(-rb) : rb;
		pr = 128'(ra_abs) * 128'(rb_abs);
		pd = 128'({1'b0, r2} + {24'b0, d}) * 128'({1'b0, r1} + {24'b0, d});
		if (pr <= pd)
			return ST_OK;
		num = pr - pd;
		prod = num * 128'(scale);
		dv = 128'(den) << 16;
		if (prod >= (dv << 16))
			dist_mm = 16'hFFFF;
		else
			dist_mm = 16'(prod / dv);
		return ST_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		range_word_t w, got;
		rec_t nr;
		if (!arst_n) begin
			owed_q.delete();
			owed = 0;
			errors = 0;
			cur_bank = 1'b0;
			tag_send = '0;
			tx_dly = TX_DLY_RST;
			rx_dly = RX_DLY_RST;
			scale = SCALE_RST;
			for (int i = 0; i < ANCHORS; i++) begin
				bank[0][i] = '0;
				bank[1][i] = '0;
				dist_store[i] = '0;
			end
		end else begin
			// Register writes.
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_TX_DLY: tx_dly = cfg.data[15:0];
					REG_RX_DLY: rx_dly = cfg.data[15:0];
					REG_SCALE:  scale = cfg.data;
					default: ;
				endcase
			end
			// Result words against the oldest owed one.
			if (result.valid && result.ready) begin
				got.anchor = result.result_anchor;
				got.dist_mm = result.distance_mm;
				got.status = status_t'(result.status);
				if (owed_q.size() == 0) begin
					report($sformatf("result word with none owed: anchor %0d dist %0d",
						got.anchor, got.dist_mm));
				end else begin
					w = owed_q.pop_front();
					if (got.anchor !== w.anchor)
						report($sformatf("anchor %0d, wanted %0d", got.anchor, w.anchor));
					if (got.dist_mm !== w.dist_mm)
						report($sformatf("anchor %0d distance %0d, wanted %0d",
							w.anchor, got.dist_mm, w.dist_mm));
					if (got.status !== w.status)
						report($sformatf("anchor %0d status %s, wanted %s",
							w.anchor, got.status.name(), w.status.name()));
				end
			end
			// Item words update the model and may owe a result.
			if (item.valid && item.ready) begin
				case (action_t'(item.action))
					ACT_SUPERFRAME: begin
						cur_bank = ~cur_bank;
						for (int i = 0; i < ANCHORS; i++) begin
							bank[cur_bank][i] = '0;
							dist_store[i] = '0;
						end
					end
					ACT_TAG_TX: tag_send = item.timestamp;
					default: begin
						w.anchor = item.anchor_id;
						w.dist_mm = '0;
						w.status = ST_OK;
						if (item.anchor_id >= ANCHORS) begin
							w.status = ST_BAD_ID;
						end else if (action_t'(item.action) == ACT_READ) begin
							w.dist_mm = dist_store[item.anchor_id[AW-1:0]];
						end else begin
							nr.valid = 1'b1;
							nr.anchor_rx = item.timestamp;
							nr.anchor_tx = item.anchor_tx_ts;
							nr.tag_rx = item.tag_rx_ts;
							if (!bank[~cur_bank][item.anchor_id[AW-1:0]].valid) begin
								w.status = ST_NO_ROUND;
							end else begin
								w.status = range_mm(bank[~cur_bank][item.anchor_id[AW-1:0]],
									nr, w.dist_mm);
								if (w.status == ST_OK)
									dist_store[item.anchor_id[AW-1:0]] = w.dist_mm;
							end
							bank[cur_bank][item.anchor_id[AW-1:0]] = nr;
						end
						owed_q.push_back(w);
					end
				endcase
			end
			owed = owed_q.size();
		end
	end

endmodule
`default_nettype wire

// ----- verif/uwb_ds_twr_ranging_table_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uwb_ds_twr_ranging_table_test
// Drives the ranging table with directed words and then with superframes of
// consistent anchor exchanges, mixed with reads, broken messages and noise,
// under several delay and scale settings. Both sides stall at random. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module uwb_ds_twr_ranging_table_test import dstwr_pkg::*;;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	logic clk;
	logic arst_n;
	int   errors;
	int   owed;
	bit   calm;
	int   words_sent;
	int   idle_cycles;

	logic [39:0] tag_time;
	logic [39:0] anchor_offs[ANCHORS];

	dstwr_in_if  item();
	dstwr_out_if result();
	dstwr_cfg_if cfg();

	uwb_ds_twr_ranging_table dut (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result), .cfg(cfg)
	);

	uwb_ds_twr_ranging_table_checker checker_i (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result), .cfg(cfg),
		.errors(errors), .owed(owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [39:0] rand40();
		logic [7:0] hi;
		hi = 8'($urandom);
		return {hi, $urandom};
	endfunction

	// Send one item word after a random gap.
	task automatic send(input action_t a, input logic [39:0] ts, input logic [7:0] id,
			input logic [39:0] atx, input logic [39:0] trx);
		int gap;
		logic rdy;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.action <= a;
		item.timestamp <= ts;
		item.anchor_id <= id;
		item.anchor_tx_ts <= atx;
		item.tag_rx_ts <= trx;
		do begin
			@(negedge clk) rdy = item.ready;
			@(posedge clk);
		end while (!rdy);
		words_sent++;
	endtask

	// Hold off until every owed result has come and the block has gone quiet.
	task automatic settle();
		item.valid <= 1'b0;
		while (owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] value);
		logic rdy;
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do begin
			@(negedge clk) rdy = cfg.ready;
			@(posedge clk);
		end while (!rdy);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [15:0] txd, input logic [15:0] rxd,
			input logic [23:0] sc);
		settle();
		write_reg(REG_TX_DLY, {8'b0, txd});
		write_reg(REG_RX_DLY, {8'b0, rxd});
		write_reg(REG_SCALE, sc);
	endtask

	// A well-formed anchor reply to the last tag send, sometimes broken.
	task automatic anchor_msg(input int id);
		logic [39:0] tof, rep, trx, atx, rx;
		tof = 40'($urandom_range(0, 20000));
		rep = 40'($urandom_range(1000, 200000));
		trx = tag_time + tof + anchor_offs[id];
		atx = trx + rep;
		rx = tag_time + 40'd2 * tof + rep;
		case ($urandom_range(0, 11))
			0: trx = rand40();
			1: atx = rand40();
			2: rx = rand40();
			default: ;
		endcase
		send(ACT_ANCHOR_MSG, rx, 8'(id), atx, trx);
	endtask

	// One superframe of exchanges with reads and noise mixed in.
	task automatic superframe();
		calm = ($urandom_range(0, 4) == 0);
		send(ACT_SUPERFRAME, rand40(), 8'($urandom), rand40(), rand40());
		tag_time = tag_time + 40'($urandom_range(1 << 20, 1 << 28));
		send(ACT_TAG_TX, tag_time, 8'($urandom), rand40(), rand40());
		for (int id = 0; id < ANCHORS; id++) begin
			if ($urandom_range(0, 3) != 0)
				anchor_msg(id);
			if ($urandom_range(0, 5) == 0)
				send(ACT_READ, rand40(), ($urandom_range(0, 7) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, 9)), rand40(), rand40());
			if ($urandom_range(0, 9) == 0)
				send(action_t'($urandom_range(0, 3)), rand40(), 8'($urandom),
					rand40(), rand40());
		end
	endtask

	// Result side: a random stall before every word.
	initial begin
		int w;
		logic vld;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = calm ? 0 : $urandom_range(0, 13);
			if (w > 0) begin
				result.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			result.ready <= 1'b1;
			do begin
				@(negedge clk) vld = result.valid;
				@(posedge clk);
			end while (!vld);
		end
	end

	// Watchdog on cycles with no word moving on any channel.
	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stimulus and verdict.
	initial begin
		item.valid = 1'b0;
		item.action = ACT_SUPERFRAME;
		item.timestamp = '0;
		item.anchor_id = '0;
		item.anchor_tx_ts = '0;
		item.tag_rx_ts = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_TX_DLY;
		cfg.data = '0;
		calm = 1'b0;
		words_sent = 0;
		tag_time = rand40();
		for (int i = 0; i < ANCHORS; i++)
			anchor_offs[i] = rand40();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads after reset, bad ids, missing round, zero divisor.
		send(ACT_READ, '0, 8'd0, '0, '0);
		send(ACT_READ, '1, 8'd7, '1, '1);
		send(ACT_READ, '0, 8'd8, '0, '0);
		send(ACT_ANCHOR_MSG, '1, 8'd255, '1, '1);
		send(ACT_ANCHOR_MSG, '0, 8'd1, '0, '0);
		send(ACT_ANCHOR_MSG, '1, 8'd2, '1, '1);
		send(ACT_SUPERFRAME, '1, 8'd255, '1, '1);
		send(ACT_TAG_TX, '0, 8'd0, '0, '0);
		send(ACT_ANCHOR_MSG, '0, 8'd1, '0, '0);
		send(ACT_ANCHOR_MSG, '1, 8'd2, '1, '1);
		send(ACT_ANCHOR_MSG, '0, 8'd0, '0, '0);
		send(ACT_READ, '0, 8'd1, '0, '0);
		send(ACT_READ, '0, 8'd2, '0, '0);
		send(ACT_TAG_TX, '1, 8'd0, '0, '0);
		send(ACT_ANCHOR_MSG, 40'd5, 8'd1, 40'hFF_FFFF_FFFF, 40'd3);
		send(ACT_SUPERFRAME, '0, 8'd0, '0, '0);
		send(ACT_READ, '0, 8'd1, '0, '0);
		anchor_msg(3);
		superframe();

		// The sender waits for every owed result at least once.
		settle();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1: set_regs(16'd0, 16'd0, 24'hFF_FFFF);
				2: set_regs(16'hFFFF, 16'hFFFF, 24'd0);
				3: set_regs(16'($urandom), 16'($urandom), 24'($urandom));
				4: set_regs(TX_DLY_RST, 16'd0, 24'd1);
				default: ;
			endcase
			while (words_sent < (phase + 1) * 265)
				superframe();
		end

		settle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
